/* rtl/core/dbvl_pkg.sv */
// ----------------------------------------------------------------------------
// dbvl_pkg: shared types and codes of the disc brush voxel label painter
// Request kinds, axis codes, register indexes, control structs and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dbvl_pkg;

    // request kinds
    localparam logic [1:0] KIND_PAINT = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // slice axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_SIZE_X = 3'd0;
    localparam logic [2:0] CFG_SIZE_Y = 3'd1;
    localparam logic [2:0] CFG_SIZE_Z = 3'd2;
    localparam logic [2:0] CFG_RADIUS = 3'd3;
    localparam logic [2:0] CFG_LABEL  = 3'd4;

    // shared multiply-add unit widths
    localparam int OP_W  = 8;
    localparam int ACC_W = 17;

    typedef struct packed {
        logic [6:0] lim_x;   // sizes already clamped to the store side
        logic [6:0] lim_y;
        logic [6:0] lim_z;
        logic [7:0] radius;
        logic [7:0] label;
    } dbvl_cfg_t;

    typedef struct packed {
        logic        labels_changed;
        logic [15:0] read_word;
        logic        out_of_range;
    } dbvl_res_t;

    // coordinate lies in [0, lim) on every axis
    function automatic logic in_vol(
        input logic signed [7:0] x,
        input logic signed [7:0] y,
        input logic signed [7:0] z,
        input dbvl_cfg_t         cfg
    );
        return !x[7] && (x[6:0] < cfg.lim_x) &&
               !y[7] && (y[6:0] < cfg.lim_y) &&
               !z[7] && (z[6:0] < cfg.lim_z);
    endfunction

    // magnitude of a walk offset (offsets stay within -16..16)
    function automatic logic [4:0] off_mag(input logic signed [5:0] d);
        logic signed [5:0] neg;
        neg = -d;
        return d[5] ? neg[4:0] : d[4:0];
    endfunction

    // sign-extend an offset to coordinate width
    function automatic logic signed [7:0] off_ext(input logic signed [5:0] d);
        return {{2{d[5]}}, d};
    endfunction

    // unsigned centre coordinate to signed coordinate width
    function automatic logic signed [7:0] ctr_ext(input logic [5:0] c);
        return {2'b00, c};
    endfunction

endpackage

/* rtl/core/dbvl_ram.sv */
// ----------------------------------------------------------------------------
// dbvl_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbvl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 262144
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/dbvl_mac.sv */
// ----------------------------------------------------------------------------
// dbvl_mac: shared multiply-add unit
// result = addend + op_a * op_b, registered; holds when not enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbvl_mac
    import dbvl_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [ACC_W-1:0] addend,
    input  logic [OP_W-1:0]  op_a,
    input  logic [OP_W-1:0]  op_b,
    output logic [ACC_W-1:0] result
);

    logic [ACC_W-1:0] result_reg;
    logic [ACC_W-1:0] result_next;

    assign result_next = addend + ACC_W'(op_a * op_b);

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* rtl/core/dbvl_seq.sv */
// ----------------------------------------------------------------------------
// dbvl_seq: request sequencer and disc walker
// Clears the store, serves word reads and writes, and walks the brush disc
// one offset at a time through the shared multiply-add unit and one RAM port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbvl_seq
    import dbvl_pkg::*;
#(
    parameter int SIDE       = 64,
    parameter int WORD_BITS  = 16,
    parameter int LABEL_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dbvl_cfg_t   cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [5:0]  s_voxel_x,
    input  logic [5:0]  s_voxel_y,
    input  logic [5:0]  s_voxel_z,
    input  logic [1:0]  s_slice_axis,
    input  logic [15:0] s_write_word,
    output logic        res_valid,
    input  logic        res_ready,
    output dbvl_res_t   res
);

    localparam int SIDE2 = SIDE * SIDE;
    localparam int DEPTH = SIDE * SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (WORD_BITS > 8) ? WORD_BITS : 8;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RDWAIT,
        P_RSQ,
        P_RSQW,
        P_ROW,
        P_D1,
        P_COL,
        P_TEST,
        P_MOD,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [1:0]             kind_reg, kind_next;
    logic [5:0]             cx_reg, cx_next;
    logic [5:0]             cy_reg, cy_next;
    logic [5:0]             cz_reg, cz_next;
    logic [1:0]             axis_reg, axis_next;
    logic [15:0]            wword_reg, wword_next;
    logic [4:0]             span_reg, span_next;
    logic signed [5:0]      d1_reg, d1_next;
    logic signed [5:0]      d2_reg, d2_next;
    logic [15:0]            rsq_reg, rsq_next;
    logic [8:0]             d1sq_reg, d1sq_next;
    logic signed [7:0]      px_reg, px_next;
    logic signed [7:0]      py_reg, py_next;
    logic signed [7:0]      pz_reg, pz_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic                   changed_reg, changed_next;
    logic [15:0]            rword_reg, rword_next;
    logic                   oor_reg, oor_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [WORD_BITS-1:0]   ram_rdata;

    logic                   mac_en;
    logic [ACC_W-1:0]       mac_addend;
    logic [OP_W-1:0]        mac_a;
    logic [OP_W-1:0]        mac_b;
    logic [ACC_W-1:0]       mac_res;

    logic [4:0]             span_calc;
    logic [8:0]             span_sum;
    logic signed [5:0]      span_s;
    logic signed [5:0]      neg_span;
    logic                   last_col;
    logic                   last_row;
    logic                   ctr_in;
    logic                   hit;
    logic [AW-1:0]          ctr_addr;
    logic [AW-1:0]          p_addr;
    logic [CW-1:0]          lm;
    logic [CW-1:0]          lab;
    logic [CW-1:0]          old_ext;
    logic                   differs;
    logic [WORD_BITS-1:0]   new_word;
    logic                   walk_ok;

    function automatic logic [AW-1:0] cell_addr(
        input logic [6:0] x,
        input logic [6:0] y,
        input logic [6:0] z
    );
        return AW'(x) * AW'(SIDE2) + AW'(y) * AW'(SIDE) + AW'(z);
    endfunction

    dbvl_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    dbvl_mac u_mac (
        .aclk   (aclk),
        .en     (mac_en),
        .addend (mac_addend),
        .op_a   (mac_a),
        .op_b   (mac_b),
        .result (mac_res)
    );

    // walk bounds
    assign span_sum  = {1'b0, cfg.radius} + 9'd15;
    assign span_calc = span_sum[8:4];
    assign span_s    = $signed({1'b0, span_reg});
    assign neg_span  = -span_s;
    assign last_col  = (d2_reg == span_s);
    assign last_row  = (d1_reg == span_s);

    assign ctr_in   = in_vol(ctr_ext(cx_reg), ctr_ext(cy_reg), ctr_ext(cz_reg), cfg);
    assign ctr_addr = cell_addr({1'b0, cx_reg}, {1'b0, cy_reg}, {1'b0, cz_reg});
    assign p_addr   = cell_addr(px_reg[6:0], py_reg[6:0], pz_reg[6:0]);

    // disc test: 256 * (d1^2 + d2^2) <= R^2, and the point lies inside the volume
    assign hit = ({mac_res, 8'h00} <= 25'(rsq_reg)) && in_vol(px_reg, py_reg, pz_reg, cfg);

    // label merge
    always_comb begin
        for (int i = 0; i < CW; i++) begin
            lm[i] = (i < LABEL_BITS);
        end
        lab      = CW'(cfg.label) & lm;
        old_ext  = CW'(ram_rdata);
        differs  = ((old_ext & lm) != lab);
        new_word = WORD_BITS'((old_ext & ~lm) | lab);
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        kind_next    = kind_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        axis_next    = axis_reg;
        wword_next   = wword_reg;
        span_next    = span_reg;
        d1_next      = d1_reg;
        d2_next      = d2_reg;
        rsq_next     = rsq_reg;
        d1sq_next    = d1sq_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pz_next      = pz_reg;
        addr_next    = addr_reg;
        changed_next = changed_reg;
        rword_next   = rword_reg;
        oor_next     = oor_reg;
        ram_we       = 1'b0;
        ram_addr     = addr_reg;
        ram_wdata    = '0;
        mac_en       = 1'b0;
        mac_addend   = '0;
        mac_a        = '0;
        mac_b        = '0;
        res_valid    = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    kind_next    = s_kind;
                    cx_next      = s_voxel_x;
                    cy_next      = s_voxel_y;
                    cz_next      = s_voxel_z;
                    axis_next    = s_slice_axis;
                    wword_next   = s_write_word;
                    changed_next = 1'b0;
                    rword_next   = '0;
                    oor_next     = 1'b0;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                case (kind_reg)
                    KIND_WRITE: begin
                        if (!ctr_in) begin
                            oor_next = 1'b1;
                        end else begin
                            ram_we    = 1'b1;
                            ram_addr  = ctr_addr;
                            ram_wdata = WORD_BITS'(wword_reg);
                        end
                    end
                    KIND_READ: begin
                        if (!ctr_in) begin
                            oor_next = 1'b1;
                        end else begin
                            ram_addr   = ctr_addr;
                            state_next = S_RDWAIT;
                        end
                    end
                    KIND_PAINT: begin
                        if (axis_reg == AXIS_X || axis_reg == AXIS_Y ||
                            axis_reg == AXIS_Z) begin
                            if (!ctr_in) begin
                                oor_next = 1'b1;
                            end else begin
                                span_next  = span_calc;
                                d1_next    = -$signed({1'b0, span_calc});
                                d2_next    = -$signed({1'b0, span_calc});
                                state_next = P_RSQ;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RDWAIT: begin
                rword_next = 16'(ram_rdata);
                state_next = S_DONE;
            end
            P_RSQ: begin
                mac_en     = 1'b1;
                mac_a      = cfg.radius;
                mac_b      = cfg.radius;
                state_next = P_RSQW;
            end
            P_RSQW: begin
                rsq_next   = mac_res[15:0];
                state_next = P_ROW;
            end
            P_ROW: begin
                mac_en     = 1'b1;
                mac_a      = OP_W'(off_mag(d1_reg));
                mac_b      = OP_W'(off_mag(d1_reg));
                state_next = P_D1;
            end
            P_D1: begin
                d1sq_next  = mac_res[8:0];
                state_next = P_COL;
            end
            P_COL: begin
                mac_en     = 1'b1;
                mac_addend = ACC_W'(d1sq_reg);
                mac_a      = OP_W'(off_mag(d2_reg));
                mac_b      = OP_W'(off_mag(d2_reg));
                case (axis_reg)
                    AXIS_X: begin
                        px_next = ctr_ext(cx_reg);
                        py_next = ctr_ext(cy_reg) + off_ext(d1_reg);
                        pz_next = ctr_ext(cz_reg) + off_ext(d2_reg);
                    end
                    AXIS_Y: begin
                        py_next = ctr_ext(cy_reg);
                        pz_next = ctr_ext(cz_reg) + off_ext(d1_reg);
                        px_next = ctr_ext(cx_reg) + off_ext(d2_reg);
                    end
                    default: begin
                        pz_next = ctr_ext(cz_reg);
                        px_next = ctr_ext(cx_reg) + off_ext(d1_reg);
                        py_next = ctr_ext(cy_reg) + off_ext(d2_reg);
                    end
                endcase
                state_next = P_TEST;
            end
            P_TEST, P_MOD: begin
                if (state_reg == P_TEST && hit) begin
                    ram_addr   = p_addr;
                    addr_next  = p_addr;
                    state_next = P_MOD;
                end else begin
                    if (state_reg == P_MOD && differs) begin
                        ram_we       = 1'b1;
                        ram_wdata    = new_word;
                        changed_next = 1'b1;
                    end
                    if (last_col) begin
                        if (last_row) begin
                            state_next = S_DONE;
                        end else begin
                            d1_next    = d1_reg + 6'sd1;
                            d2_next    = neg_span;
                            state_next = P_ROW;
                        end
                    end else begin
                        d2_next    = d2_reg + 6'sd1;
                        state_next = P_COL;
                    end
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
        kind_reg    <= kind_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        axis_reg    <= axis_next;
        wword_reg   <= wword_next;
        span_reg    <= span_next;
        d1_reg      <= d1_next;
        d2_reg      <= d2_next;
        rsq_reg     <= rsq_next;
        d1sq_reg    <= d1sq_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        pz_reg      <= pz_next;
        addr_reg    <= addr_next;
        changed_reg <= changed_next;
        rword_reg   <= rword_next;
        oor_reg     <= oor_next;
    end

    assign res.labels_changed = changed_reg;
    assign res.read_word      = rword_reg;
    assign res.out_of_range   = oor_reg;

    assign walk_ok = (d1_reg >= neg_span) && (d1_reg <= span_s) &&
                     (d2_reg >= neg_span) && (d2_reg <= span_s);

`ifndef SYNTHESIS
    a_we_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_DECODE || state_reg == P_MOD))
        else $error("store written outside clear, word write or label update");

    a_walk_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == P_COL || state_reg == P_TEST || state_reg == P_MOD) |-> walk_ok)
        else $error("disc walk offset beyond span");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (state_reg == S_DONE && $stable(res)))
        else $error("pending result lost or changed");

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");
`endif

endmodule

/* rtl/core/disc_brush_voxel_label_painter_top.sv */
// ----------------------------------------------------------------------------
// disc_brush_voxel_label_painter_top: disc brush voxel label painter
// A word write is decoded and written in S_DECODE; its result then passes
//   S_DONE into the output register that drives m_valid. A read adds S_RDWAIT.
// A paint squares the radius, then walks 2n+1 rows of 2n+1 offsets with
//   n = ceil(radius / 16), rewriting voxels in disc and volume on a change.
// The walk is bound by the single store port and the shared multiply-add unit.
// One request at a time; the next is taken while a result waits on m_ready.
// Reset clears all SIDE^3 store words (262144 by default) with s_ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module disc_brush_voxel_label_painter_top
    import dbvl_pkg::*;
#(
    parameter int SIDE       = 64,
    parameter int WORD_BITS  = 16,
    parameter int LABEL_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [5:0]  s_voxel_x,
    input  logic [5:0]  s_voxel_y,
    input  logic [5:0]  s_voxel_z,
    input  logic [1:0]  s_slice_axis,
    input  logic [15:0] s_write_word,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_labels_changed,
    output logic [15:0] m_read_word,
    output logic        m_out_of_range
);

    // Configuration registers. Writes are taken every cycle; the user only
    // writes while no request is in flight.
    logic [6:0] size_x_reg;
    logic [6:0] size_y_reg;
    logic [6:0] size_z_reg;
    logic [7:0] radius_reg;
    logic [7:0] label_reg;

    dbvl_cfg_t  cfg;
    logic       res_valid;
    logic       res_ready;
    dbvl_res_t  res;

    // Result output register, so the sequencer can go back for the next
    // request while this one waits for m_ready.
    logic       m_valid_reg;
    dbvl_res_t  m_res_reg;

    // A size beyond the store side is clamped; zero leaves nothing inside.
    function automatic logic [6:0] clamp_size(input logic [6:0] size);
        return ({2'b00, size} > 9'(SIDE)) ? 7'(SIDE) : size;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= 7'd64;
            size_y_reg <= 7'd64;
            size_z_reg <= 7'd64;
            radius_reg <= 8'd16;
            label_reg  <= 8'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data[6:0];
                CFG_SIZE_Y: size_y_reg <= cfg_data[6:0];
                CFG_SIZE_Z: size_z_reg <= cfg_data[6:0];
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_LABEL:  label_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.lim_x  = clamp_size(size_x_reg);
    assign cfg.lim_y  = clamp_size(size_y_reg);
    assign cfg.lim_z  = clamp_size(size_z_reg);
    assign cfg.radius = radius_reg;
    assign cfg.label  = label_reg;

    // Sequencer: owns the store, the walk and the shared multiply-add unit.
    dbvl_seq #(
        .SIDE       (SIDE),
        .WORD_BITS  (WORD_BITS),
        .LABEL_BITS (LABEL_BITS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_voxel_x    (s_voxel_x),
        .s_voxel_y    (s_voxel_y),
        .s_voxel_z    (s_voxel_z),
        .s_slice_axis (s_slice_axis),
        .s_write_word (s_write_word),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // Output register loads whenever it is empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_labels_changed = m_res_reg.labels_changed;
    assign m_read_word      = m_res_reg.read_word;
    assign m_out_of_range   = m_res_reg.out_of_range;

endmodule
